// File: src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and tables of the SHA-256 digest unit.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenStart   = 56;
  localparam int unsigned NumRounds  = 64;
  localparam int unsigned NumWords   = 8;

  localparam logic [7:0] PadByte = 8'h80;

  // source of the byte that enters the block buffer
  typedef enum logic [1:0] {
    BYTE_MSG,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } sha256_byte_sel_e;

  typedef struct packed {
    logic             shift_en;
    sha256_byte_sel_e byte_sel;
    logic             load_rounds;
    logic             round_en;
    logic [5:0]       round_idx;
    logic             add_hash;
    logic             init_hash;
    logic             out_load;
    logic [2:0]       out_idx;
  } sha256_cmd_t;

  function automatic logic [31:0] sha256_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sha256_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: src/sha256_if.sv
// ----------------------------------------------------------------------------
// sha256 stream interfaces
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] message_byte;

  modport source (output valid, output func, output message_byte, input ready);
  modport sink   (input valid, input func, input message_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// File: src/sha256_datapath.sv
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer and schedule window, round unit, hash words, length counter
// and output word register.
// ----------------------------------------------------------------------------
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha256_cmd_t cmd_i,
  input  logic [7:0]  message_byte_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // bytes shift into the schedule window, so after 64 bytes w_q[0] is word 0
  logic [31:0] w_q   [16];
  logic [31:0] w_d   [16];
  logic [31:0] rw_q  [8];
  logic [31:0] rw_d  [8];
  logic [31:0] hash_q[8];
  logic [31:0] hash_d[8];
  logic [63:0] bit_cnt_q, bit_cnt_d;
  logic [31:0] digest_q;
  logic [2:0]  index_q;
  logic        last_q;

  logic [7:0]  byte_in;
  logic [31:0] w_next, s0, s1, sum0, sum1, ch, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    case (cmd_i.byte_sel)
      BYTE_MSG:  byte_in = message_byte_i;
      BYTE_PAD:  byte_in = PadByte;
      BYTE_LEN:  byte_in = bit_cnt_q[63:56];
      default:   byte_in = 8'h00;
    endcase
  end

  always_comb begin
    s0     = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1     = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_next = s1 + w_q[9] + s0 + w_q[0];
    sum1   = rotr(rw_q[4], 6) ^ rotr(rw_q[4], 11) ^ rotr(rw_q[4], 25);
    sum0   = rotr(rw_q[0], 2) ^ rotr(rw_q[0], 13) ^ rotr(rw_q[0], 22);
    ch     = (rw_q[4] & rw_q[5]) ^ (~rw_q[4] & rw_q[6]);
    maj    = (rw_q[0] & rw_q[1]) ^ (rw_q[0] & rw_q[2]) ^ (rw_q[1] & rw_q[2]);
    t1     = rw_q[7] + sum1 + ch + sha256_k(cmd_i.round_idx) + w_q[0];
    t2     = sum0 + maj;
  end

  always_comb begin
    w_d       = w_q;
    rw_d      = rw_q;
    hash_d    = hash_q;
    bit_cnt_d = bit_cnt_q;
    if (cmd_i.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[15] = {w_q[15][23:0], byte_in};
      if (cmd_i.byte_sel == BYTE_MSG) begin
        bit_cnt_d = bit_cnt_q + 64'd8;
      end else if (cmd_i.byte_sel == BYTE_LEN) begin
        // length leaves top byte first and ends at zero for the next message
        bit_cnt_d = {bit_cnt_q[55:0], 8'h00};
      end
    end
    if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_next;
      for (int i = 7; i > 0; i--) begin
        rw_d[i] = rw_q[i-1];
      end
      rw_d[4] = rw_q[3] + t1;
      rw_d[0] = t1 + t2;
    end
    if (cmd_i.load_rounds) begin
      rw_d = hash_q;
    end
    if (cmd_i.add_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + rw_q[i];
      end
    end
    if (cmd_i.init_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = sha256_iv(3'(i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha256_iv(3'(i));
      end
      bit_cnt_q <= '0;
    end else begin
      hash_q    <= hash_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    rw_q <= rw_d;
    if (cmd_i.out_load) begin
      digest_q <= hash_q[cmd_i.out_idx];
      index_q  <= cmd_i.out_idx;
      last_q   <= (cmd_i.out_idx == 3'(NumWords - 1));
    end
  end

  assign digest_word_o = digest_q;
  assign word_index_o  = index_q;
  assign last_word_o   = last_q;

endmodule

// File: src/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer for byte absorb, padding, round iteration and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_func_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output sha256_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       fin_q, fin_d;
  logic       first_q, first_d;
  logic       len_ok_q, len_ok_d;
  logic       last_blk_q, last_blk_d;
  logic       out_valid_q, out_valid_d;
  logic       in_ready;

  assign in_ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    fin_d       = fin_q;
    first_d     = first_q;
    len_ok_d    = len_ok_q;
    last_blk_d  = last_blk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.byte_sel  = BYTE_MSG;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!in_func_i) begin
            cmd_o.shift_en = 1'b1;
            fill_d = fill_q + 6'd1;
            if (fill_q == 6'(BlockBytes - 1)) begin
              cmd_o.load_rounds = 1'b1;
              rnd_d   = '0;
              fin_d   = 1'b0;
              state_d = ST_ROUND;
            end
          end else begin
            fin_d   = 1'b1;
            first_d = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.shift_en = 1'b1;
        if (first_q) begin
          cmd_o.byte_sel = BYTE_PAD;
          first_d  = 1'b0;
          // length fits behind the pad byte only below byte 56
          len_ok_d = (fill_q < 6'(LenStart));
        end else if (len_ok_q && fill_q >= 6'(LenStart)) begin
          cmd_o.byte_sel = BYTE_LEN;
        end else begin
          cmd_o.byte_sel = BYTE_ZERO;
        end
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'(BlockBytes - 1)) begin
          cmd_o.load_rounds = 1'b1;
          rnd_d      = '0;
          last_blk_d = !first_q && len_ok_q;
          state_d    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(NumRounds - 1)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.add_hash = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (last_blk_q) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          len_ok_d = 1'b1;
          state_d  = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          idx_d          = idx_q + 3'd1;
          if (idx_q == 3'(NumWords - 1)) begin
            cmd_o.init_hash = 1'b1;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rnd_q       <= '0;
      idx_q       <= '0;
      fin_q       <= 1'b0;
      first_q     <= 1'b0;
      len_ok_q    <= 1'b0;
      last_blk_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      fin_q       <= fin_d;
      first_q     <= first_d;
      len_ok_q    <= len_ok_d;
      last_blk_q  <= last_blk_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

// File: src/sha256_message_digest_unit.sv
// ----------------------------------------------------------------------------
// sha256_message_digest_unit
// SHA-256 over a byte stream, digest returned as eight 32-bit words.
// ----------------------------------------------------------------------------
// An absorb word shifts one message byte into the buffer. Every 64th byte
// starts a compression that runs one round per cycle on a single round unit
// and then folds into the hash, and input is held off meanwhile. A finish
// word feeds the padding and length bytes one a cycle into the same buffer
// (up to 64, or up to 72 when a second block is needed), runs one or two
// compressions, then hands out the eight digest words one a cycle as the
// sink takes them. The last digest word may still wait in the output
// register while the next message is being absorbed.
module sha256_message_digest_unit
  import sha256_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  sha256_in_if.sink     msg_i,
  sha256_out_if.source  dig_o
);

  sha256_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .in_func_i   (msg_i.func),
    .in_ready_o  (msg_i.ready),
    .out_ready_i (dig_o.ready),
    .out_valid_o (dig_o.valid),
    .cmd_o       (cmd)
  );

  sha256_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .message_byte_i (msg_i.message_byte),
    .digest_word_o  (dig_o.digest_word),
    .word_index_o   (dig_o.word_index),
    .last_word_o    (dig_o.last_word)
  );

endmodule
